// File: rtl/core/yqe_pkg.sv
// yqe_pkg: shared types, constants and the quadrature phase table
// for the yaw to quadrature emulator. No dependencies.
`timescale 1ns / 1ps

package yqe_pkg;

  localparam int unsigned YAW_W          = 20;
  localparam int unsigned TURN_W         = 16;
  localparam int unsigned CFG_W          = 19;
  localparam int unsigned PROD_W         = 36;
  localparam int unsigned IN_TDATA_W     = 24;
  localparam int unsigned OUT_TDATA_W    = 8;
  localparam int unsigned POSITION_BITS  = 40;

  localparam logic [CFG_W-1:0] STEP_INC_RESET  = 19'd3214;
  localparam logic [CFG_W-1:0] FULL_TURN_RESET = 19'd360000;

  typedef enum logic {
    CFG_STEP_INC  = 1'b0,
    CFG_FULL_TURN = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    DIR_FWD = 1'b0,
    DIR_REV = 1'b1
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POS,
    ST_CMP,
    ST_DIV,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic start;
    dir_e dir;
  } emit_ctrl_t;

  // Returns {chan_b, chan_a} for a phase of the cycle.
  function automatic logic [1:0] phase_ba(dir_e dir, logic [1:0] idx);
    logic [1:0] ba;
    ba = 2'b00;
    unique case (dir)
      DIR_FWD: begin
        unique case (idx)
          2'd0: ba = 2'b01;
          2'd1: ba = 2'b11;
          2'd2: ba = 2'b10;
          default: ba = 2'b00;
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: ba = 2'b10;
          2'd1: ba = 2'b11;
          2'd2: ba = 2'b01;
          default: ba = 2'b00;
        endcase
      end
    endcase
    return ba;
  endfunction

endpackage

// File: rtl/core/yqe_rem_unit.sv
// yqe_rem_unit: bit-serial remainder, one compare-subtract per cycle.
// Depends on yqe_pkg.
`timescale 1ns / 1ps

module yqe_rem_unit #(
  parameter int unsigned PB = yqe_pkg::POSITION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [PB-1:0]             dividend_i,
  input  logic [yqe_pkg::CFG_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [yqe_pkg::CFG_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(PB);
  localparam int unsigned RW = yqe_pkg::CFG_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PB-1:0] sh_q, sh_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [RW:0]   trial;
  logic [RW:0]   diff;

  assign trial = {rem_q, sh_q[PB-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      sh_d  = {sh_q[PB-2:0], 1'b0};
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[RW-1:0] : trial[RW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(PB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/yqe_phase_gen.sv
// yqe_phase_gen: registered output stage, plays one four-phase
// quadrature cycle on the master stream. Depends on yqe_pkg.
`timescale 1ns / 1ps

module yqe_phase_gen (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  yqe_pkg::emit_ctrl_t             ctrl_i,
  output logic                            busy_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [yqe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o, // [0] chan_a, [1] chan_b
  output logic                            m_axis_tlast_o
);

  logic          active_q, active_d;
  logic [1:0]    idx_q, idx_d;
  yqe_pkg::dir_e dir_q, dir_d;
  logic [1:0]    ba;

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    dir_d    = dir_q;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      idx_d    = 2'd0;
      dir_d    = ctrl_i.dir;
    end else if (active_q && m_axis_tready_i) begin
      if (idx_q == 2'd3) begin
        active_d = 1'b0;
      end
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= 2'd0;
      dir_q    <= yqe_pkg::DIR_FWD;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      dir_q    <= dir_d;
    end
  end

  assign ba              = yqe_pkg::phase_ba(dir_q, idx_q);
  assign busy_o          = active_q;
  assign m_axis_tvalid_o = active_q;
  assign m_axis_tdata_o  = {{(yqe_pkg::OUT_TDATA_W - 2){1'b0}}, ba};
  assign m_axis_tlast_o  = (idx_q == 2'd3);

endmodule

// File: rtl/core/yaw_to_quadrature_emulator.sv
// Yaw to quadrature emulator top level: sequencer, position datapath.
// Depends on yqe_pkg, yqe_rem_unit and yqe_phase_gen.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one yaw sample (signed millidegrees) per transfer.
//   m_axis carries quadrature phases: tdata[0] = A, tdata[1] = B, and
//   tlast marks the fourth phase. A sample gives either no phase or one
//   full forward or reverse cycle of four phases.
//   cfg_* writes step_increment (index 0) or full_turn (index 1); always
//   ready, write only while the block is idle.
// Timing:
//   One sample at a time; s_axis_tready_o is high only when idle.
//   A sample that moves nothing goes through multiply, position and
//   compare and back to idle. Otherwise the remainder of the angle step
//   is found bit-serially, one bit per cycle, in the divide state; the
//   finish state then moves the tracked angle and starts the four phases,
//   and the next sample is taken once the last phase has left.
//   A stalled receiver holds the current phase; the block waits.
// Reset: turn count, previous sample and tracked angle clear to zero,
//   registers return to 3214 and 360000.

module yaw_to_quadrature_emulator #(
  parameter int unsigned PB = yqe_pkg::POSITION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [yqe_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i, // [19:0] yaw_mdeg
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [yqe_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o, // [0] chan_a, [1] chan_b
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [yqe_pkg::CFG_W-1:0]       cfg_data_i
);

  localparam int unsigned YW = yqe_pkg::YAW_W;
  localparam int unsigned TW = yqe_pkg::TURN_W;
  localparam int unsigned RW = yqe_pkg::CFG_W;
  localparam int unsigned MW = yqe_pkg::PROD_W;
  localparam int unsigned SW = (PB > MW) ? PB : MW;

  yqe_pkg::state_e state_q, state_d;

  logic [RW-1:0]        step_q, full_q;
  logic signed [TW-1:0] turn_q, turn_d;
  logic signed [YW-1:0] prev_q, prev_d;
  logic [PB-1:0]        ang_q, ang_d;
  logic signed [YW-1:0] yaw_q;
  logic signed [MW-1:0] prod_q;
  logic [PB-1:0]        pos_q;
  yqe_pkg::dir_e        dir_q, dir_d;

  logic [RW-1:0]        inc;
  logic [PB-1:0]        inc_ext;
  logic signed [SW-1:0] sum;
  logic                 ang_lt_pos, pos_lt_ang, rev_ok;
  logic [PB-1:0]        diff_fwd, diff_rev, dividend;
  logic [RW-1:0]        adj;
  logic                 rem_start, rem_done;
  logic [RW-1:0]        rem;
  yqe_pkg::emit_ctrl_t  emit_ctrl;
  logic                 emit_busy;
  logic                 in_xfer;

  assign in_xfer     = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= yqe_pkg::STEP_INC_RESET;
      full_q <= yqe_pkg::FULL_TURN_RESET;
    end else if (cfg_valid_i) begin
      unique case (yqe_pkg::cfg_idx_e'(cfg_index_i))
        yqe_pkg::CFG_STEP_INC:  step_q <= cfg_data_i;
        yqe_pkg::CFG_FULL_TURN: full_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign inc     = (step_q == '0) ? RW'(1) : step_q;
  assign inc_ext = PB'(inc);

  assign sum        = SW'(prod_q) + SW'(yaw_q);
  assign ang_lt_pos = $signed(ang_q) < $signed(pos_q);
  assign pos_lt_ang = $signed(pos_q) < $signed(ang_q);
  assign diff_fwd   = pos_q - ang_q;
  assign diff_rev   = ang_q - pos_q;
  assign rev_ok     = pos_lt_ang && (diff_rev > inc_ext);
  assign dividend   = ang_lt_pos ? diff_fwd : (diff_rev - inc_ext);

  // ceil(d/inc)*inc folded into a remainder correction
  always_comb begin
    adj = '0;
    unique case (dir_q)
      yqe_pkg::DIR_FWD: adj = (rem != '0) ? (inc - rem) : '0;
      default:          adj = (rem != '0) ? rem : inc;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      yqe_pkg::ST_IDLE: if (in_xfer) state_d = yqe_pkg::ST_MUL;
      yqe_pkg::ST_MUL:  state_d = yqe_pkg::ST_POS;
      yqe_pkg::ST_POS:  state_d = yqe_pkg::ST_CMP;
      yqe_pkg::ST_CMP:  state_d = (ang_lt_pos || rev_ok) ? yqe_pkg::ST_DIV : yqe_pkg::ST_IDLE;
      yqe_pkg::ST_DIV:  if (rem_done) state_d = yqe_pkg::ST_FIN;
      yqe_pkg::ST_FIN:  state_d = yqe_pkg::ST_EMIT;
      yqe_pkg::ST_EMIT: if (!emit_busy) state_d = yqe_pkg::ST_IDLE;
      default:          state_d = yqe_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    s_axis_tready_o = 1'b0;
    turn_d          = turn_q;
    prev_d          = prev_q;
    ang_d           = ang_q;
    dir_d           = dir_q;
    rem_start       = 1'b0;
    emit_ctrl.start = 1'b0;
    emit_ctrl.dir   = dir_q;
    unique case (state_q)
      yqe_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      yqe_pkg::ST_POS: begin
        prev_d = yaw_q;
        if (yaw_q == '0 && prev_q > 0) begin
          turn_d = turn_q + TW'(1);
        end else if (yaw_q == '0 && prev_q < 0) begin
          turn_d = turn_q - TW'(1);
        end
      end
      yqe_pkg::ST_CMP: begin
        dir_d     = ang_lt_pos ? yqe_pkg::DIR_FWD : yqe_pkg::DIR_REV;
        rem_start = ang_lt_pos || rev_ok;
      end
      yqe_pkg::ST_FIN: begin
        ang_d           = pos_q + PB'(adj);
        emit_ctrl.start = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= yqe_pkg::ST_IDLE;
      turn_q  <= '0;
      prev_q  <= '0;
      ang_q   <= '0;
    end else begin
      state_q <= state_d;
      turn_q  <= turn_d;
      prev_q  <= prev_d;
      ang_q   <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      yaw_q <= $signed(s_axis_tdata_i[YW-1:0]);
    end
    if (state_q == yqe_pkg::ST_MUL) begin
      prod_q <= MW'(turn_q * $signed({1'b0, full_q}));
    end
    if (state_q == yqe_pkg::ST_POS) begin
      pos_q <= sum[PB-1:0];
    end
    dir_q <= dir_d;
  end

  yqe_rem_unit #(
    .PB (PB)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (dividend),
    .divisor_i  (inc),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  yqe_phase_gen u_phase (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (emit_ctrl),
    .busy_o          (emit_busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

`ifndef SYNTH
  a_valid_in_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> state_q == yqe_pkg::ST_EMIT)
    else $error("phase output outside emit");

  a_no_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input taken while phases pending");

  a_rem_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> state_q == yqe_pkg::ST_DIV)
    else $error("remainder done outside divide step");

  a_angle_only_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != yqe_pkg::ST_FIN |=> $stable(ang_q))
    else $error("tracked angle moved outside finish step");
`endif

endmodule
